// File: rtl/msp_pkg.sv
`timescale 1ns / 1ps

package msp_pkg;

   localparam int NUM_STACKS  = 4;
   localparam int POOL_DEPTH  = 16;
   localparam int IDX_W       = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int PTR_W       = $clog2(POOL_DEPTH + 1);
   localparam int SID_W       = 2;
   localparam int STK_IDX_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;

   localparam logic [PTR_W-1:0]   NULL_PTR        = PTR_W'(POOL_DEPTH);
   localparam logic [VALUE_W-1:0] EMPTY_POP_VALUE = 32'h7FFF_FFFF;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } msp_state_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [PTR_W-1:0] data;
   } msp_link_wr_type;

   // anything at or past the pool depth counts as the null link
   function automatic logic is_null(input logic [PTR_W-1:0] ptr);
      return ptr >= NULL_PTR;
   endfunction

   function automatic logic [IDX_W-1:0] ptr_index(input logic [PTR_W-1:0] ptr);
      return is_null(ptr) ? '0 : ptr[IDX_W-1:0];
   endfunction

endpackage

// File: rtl/msp_link_store.sv
`timescale 1ns / 1ps

module msp_link_store import msp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IDX_W-1:0]     rd_addr,
   output logic [PTR_W-1:0]     rd_data_ff,
   input  msp_link_wr_type      wr
);

   logic [PTR_W-1:0]      link_mem [POOL_DEPTH];
   logic [POOL_DEPTH-1:0] written_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         link_mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr.en) begin
         written_ff[wr.addr] <= 1'b1;
      end
   end

   // untouched entries read as the initial chain: slot i links i+1
   always_ff @(posedge clock) begin
      if (written_ff[rd_addr]) begin
         rd_data_ff <= link_mem[rd_addr];
      end else begin
         rd_data_ff <= PTR_W'(rd_addr) + PTR_W'(1);
      end
   end

endmodule

// File: rtl/multi_stack_shared_pool.sv
`timescale 1ns / 1ps

// Several LIFO stacks sharing one pool of slots, with a linked free list.
// Request channel: start with req_type (push/pop), req_stack_id and
// req_push_value; a request is taken on a clock edge with start high and
// busy low. busy is high in the cycle after a request is taken.
// Result channel: rsp_valid strobes for one cycle with rsp_pop_value,
// rsp_status, rsp_pool_full and rsp_stack_empty; the receiver cannot stall,
// so each result must be captured in its strobe cycle.
// Timing: the request edge reads the link and value memories (synchronous
// read), the following cycle updates links, tops and free head, and the
// result appears in the cycle after that. No new request is taken while
// busy, which leaves room for the read-modify-write on the link memory.
// Reset (synchronous) empties all stacks and restores the free list to the
// full pool in slot order; it takes effect at once, with no clearing pass.

module multi_stack_shared_pool import msp_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_type,
   input  logic [SID_W-1:0]           req_stack_id,
   input  logic signed [VALUE_W-1:0]  req_push_value,
   output logic                       rsp_valid,
   output logic signed [VALUE_W-1:0]  rsp_pop_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_pool_full,
   output logic                       rsp_stack_empty
);

   msp_state_type state_ff, state_in;

   logic [PTR_W-1:0]   tops_ff [NUM_STACKS];
   logic [PTR_W-1:0]   tops_in [NUM_STACKS];
   logic [PTR_W-1:0]   free_head_ff, free_head_in;

   logic               op_ff;
   logic [SID_W-1:0]   sid_ff;
   logic [VALUE_W-1:0] val_ff;

   logic [VALUE_W-1:0] value_mem [POOL_DEPTH];
   logic [VALUE_W-1:0] value_rd_ff;
   logic               value_we;
   logic [IDX_W-1:0]   value_wr_addr;

   logic               accept;
   logic [PTR_W-1:0]   rd_ptr;
   logic [IDX_W-1:0]   rd_idx;
   logic [PTR_W-1:0]   link_rd;
   msp_link_wr_type    link_wr;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic               rsp_full_ff, rsp_full_in;
   logic               rsp_empty_ff, rsp_empty_in;

   assign busy   = (state_ff == ST_EXEC);
   assign accept = start && !busy;

   // push reads the free head's link, pop reads the top's link and value
   assign rd_ptr = (req_type == OP_PUSH) ? free_head_ff
                                         : tops_ff[req_stack_id[STK_IDX_W-1:0]];
   assign rd_idx = ptr_index(rd_ptr);

   msp_link_store u_links (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (rd_idx),
      .rd_data_ff (link_rd),
      .wr         (link_wr)
   );

   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[value_wr_addr] <= val_ff;
      end
      if (accept) begin
         value_rd_ff <= value_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_type;
         sid_ff <= req_stack_id;
         val_ff <= req_push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_STACKS; i++) begin
            tops_ff[i] <= NULL_PTR;
         end
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_STACKS; i++) begin
            tops_ff[i] <= tops_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   always_comb begin
      logic             valid_id;
      logic [PTR_W-1:0] top_cur;
      logic [PTR_W-1:0] top_new;

      valid_id = (32'(sid_ff) < NUM_STACKS);
      top_cur  = tops_ff[sid_ff[STK_IDX_W-1:0]];
      top_new  = top_cur;

      state_in      = state_ff;
      free_head_in  = free_head_ff;
      for (int i = 0; i < NUM_STACKS; i++) begin
         tops_in[i] = tops_ff[i];
      end
      link_wr       = '0;
      value_we      = 1'b0;
      value_wr_addr = ptr_index(free_head_ff);
      rsp_valid_in  = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = STATUS_DONE;
      rsp_full_in   = 1'b0;
      rsp_empty_in  = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (op_ff == OP_PUSH) begin
               if (!valid_id || is_null(free_head_ff)) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  free_head_in  = link_rd;
                  link_wr.en    = 1'b1;
                  link_wr.addr  = ptr_index(free_head_ff);
                  link_wr.data  = top_cur;
                  value_we      = 1'b1;
                  top_new       = free_head_ff;
               end
            end else begin
               if (!valid_id || is_null(top_cur)) begin
                  rsp_status_in = STATUS_EMPTY;
                  rsp_value_in  = EMPTY_POP_VALUE;
               end else begin
                  top_new       = link_rd;
                  link_wr.en    = 1'b1;
                  link_wr.addr  = ptr_index(top_cur);
                  link_wr.data  = free_head_ff;
                  free_head_in  = top_cur;
                  rsp_value_in  = value_rd_ff;
               end
            end
            if (valid_id) begin
               tops_in[sid_ff[STK_IDX_W-1:0]] = top_new;
               rsp_empty_in = is_null(top_new);
            end
            rsp_full_in = is_null(free_head_in);
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pop_value   = signed'(rsp_value_ff);
   assign rsp_status      = rsp_status_ff;
   assign rsp_pool_full   = rsp_full_ff;
   assign rsp_stack_empty = rsp_empty_ff;

endmodule
